### rtl/slid_pkg.sv
`default_nettype none
package slid_pkg;

   // list geometry
   localparam int CAPACITY_DEFAULT = 128;
   localparam int POS_W            = 8;
   localparam int DATA_W           = 32;
   localparam int STATUS_W         = 2;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic                     apply;
      logic                     is_insert;
      logic [POS_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
   } slid_cmd_type;

endpackage
`default_nettype wire

### rtl/sequential_list_insert_delete_top.sv
// positional insert/delete list held in a chain of cells, one entry per cell
// a request is registered into the request stage, then its result into the result registers and strobed
// throughput: one request per cycle; busy is low except in reset and the cycle after it
// the whole chain shifts by one place in the single apply cycle
// reset (synchronous, active high) empties the list and holds busy high through reset and the cycle after it
// results cannot be stalled by the receiver
`default_nettype none
module sequential_list_insert_delete_top #(
   parameter int CAPACITY = slid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_func,
   input  wire logic [slid_pkg::POS_W-1:0]            req_position,
   input  wire logic signed [slid_pkg::DATA_W-1:0]    req_value,
   output logic                                       rsp_strobe,
   output logic [slid_pkg::STATUS_W-1:0]              rsp_status,
   output logic signed [slid_pkg::DATA_W-1:0]         rsp_removed_value,
   output logic [slid_pkg::POS_W-1:0]                 rsp_list_length
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [slid_pkg::POS_W-1:0] CAP_COUNT = slid_pkg::POS_W'(CAPACITY);

   // busy only while coming out of reset
   logic busy_ff;

   // request stage
   logic                              stage_valid_ff;
   logic                              stage_func_ff;
   logic [slid_pkg::POS_W-1:0]        stage_pos_ff;
   logic signed [slid_pkg::DATA_W-1:0] stage_value_ff;

   // list length
   logic [slid_pkg::POS_W-1:0] count_ff;
   logic [slid_pkg::POS_W-1:0] count_in;

   // result registers
   logic                               rsp_strobe_ff;
   logic [slid_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [slid_pkg::STATUS_W-1:0]      rsp_status_in;
   logic signed [slid_pkg::DATA_W-1:0] rsp_removed_ff;
   logic signed [slid_pkg::DATA_W-1:0] rsp_removed_in;

   logic                       accept;
   logic [slid_pkg::POS_W:0]   pos_ext;
   logic [slid_pkg::POS_W:0]   count_ext;
   logic                       pos_ok;
   logic [slid_pkg::POS_W-1:0] idx;
   slid_pkg::slid_cmd_type     cmd;

   // cell outputs, each read by its neighbor cells plus the removal select
   logic signed [slid_pkg::DATA_W-1:0] cell_data [CAPACITY];

   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         stage_valid_ff <= accept;
         count_ff       <= count_in;
         rsp_strobe_ff  <= stage_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_func_ff  <= req_func;
         stage_pos_ff   <= req_position;
         stage_value_ff <= req_value;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   // position check against the length left by the previous request
   assign pos_ext   = {1'b0, stage_pos_ff};
   assign count_ext = {1'b0, count_ff};
   assign idx       = stage_pos_ff - slid_pkg::POS_W'(1);

   always_comb begin
      if (stage_func_ff == slid_pkg::FUNC_INSERT) begin
         pos_ok = (stage_pos_ff != '0) && (pos_ext <= count_ext + (slid_pkg::POS_W+1)'(1));
      end else begin
         pos_ok = (stage_pos_ff != '0) && (pos_ext <= count_ext);
      end
   end

   always_comb begin
      cmd.apply      = 1'b0;
      cmd.is_insert  = (stage_func_ff == slid_pkg::FUNC_INSERT);
      cmd.idx        = idx;
      cmd.value      = stage_value_ff;
      count_in       = count_ff;
      rsp_status_in  = slid_pkg::STATUS_OK;
      rsp_removed_in = '0;
      if (stage_valid_ff) begin
         if (!pos_ok) begin
            rsp_status_in = slid_pkg::STATUS_BAD_POS;
         end else if (stage_func_ff == slid_pkg::FUNC_INSERT) begin
            if (count_ff == CAP_COUNT) begin
               rsp_status_in = slid_pkg::STATUS_FULL;
            end else begin
               cmd.apply = 1'b1;
               count_in  = count_ff + slid_pkg::POS_W'(1);
            end
         end else begin
            // idx is below the length here, so inside the chain
            cmd.apply      = 1'b1;
            count_in       = count_ff - slid_pkg::POS_W'(1);
            rsp_removed_in = cell_data[idx[IDX_W-1:0]];
         end
      end
   end

   // the chain: on insert cells past the place take their left neighbor, on delete cells from the place on their right
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [slid_pkg::DATA_W-1:0] left_data;
      logic signed [slid_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      slid_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_list_length   = count_ff;

`ifndef SYNTHESIS
   // length never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("list length above capacity");

   // a result follows in the cycle after a staged request
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |=> rsp_strobe)
      else $error("staged request gave no result");

   // a failed request leaves the length unchanged
   a_fail_keeps_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != slid_pkg::STATUS_OK) |->
         rsp_list_length == $past(count_ff))
      else $error("failed request changed the length");

   // a removed value only comes with a good status
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_removed_value != '0) |-> rsp_status == slid_pkg::STATUS_OK)
      else $error("removed value with error status");
`endif

endmodule
`default_nettype wire

### rtl/slid_cell.sv
`default_nettype none
module slid_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                             clock,
   input  wire slid_pkg::slid_cmd_type           cmd,
   input  wire logic signed [slid_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [slid_pkg::DATA_W-1:0] right_data,
   output logic signed [slid_pkg::DATA_W-1:0]      data
);

   localparam logic [slid_pkg::POS_W-1:0] MY_IDX = slid_pkg::POS_W'(CELL_INDEX);

   logic signed [slid_pkg::DATA_W-1:0] data_ff;
   logic signed [slid_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.apply) begin
         if (cmd.is_insert) begin
            if (cmd.idx == MY_IDX) begin
               data_in = cmd.value;
            end else if (MY_IDX > cmd.idx) begin
               data_in = left_data;
            end
         end else if (MY_IDX >= cmd.idx) begin
            data_in = right_data;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire
